FILE: rtl/core/sm83_pkg.sv
// Shared constants, types and helpers for the SM83 block-zero execute unit.
package sm83_pkg;

  localparam int MEM_ADDR_BITS = 16;
  localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

  // Flag bit positions in F.
  localparam int FZ = 7;
  localparam int FN = 6;
  localparam int FH = 5;
  localparam int FC = 4;

  // Register file indexes.
  localparam logic [2:0] IDX_A = 3'd0;
  localparam logic [2:0] IDX_F = 3'd1;
  localparam logic [2:0] IDX_H = 3'd6;
  localparam logic [2:0] IDX_L = 3'd7;

  // Special opcodes in the first quarter of the map.
  localparam logic [5:0] OP_NOP       = 6'h00;
  localparam logic [5:0] OP_LD_A16_SP = 6'h08;
  localparam logic [5:0] OP_JR        = 6'h18;
  localparam logic [5:0] OP_JR_Z      = 6'h28;
  localparam logic [5:0] OP_JR_C      = 6'h38;

  // Low three opcode bits: operation group.
  localparam logic [2:0] GRP_MISC  = 3'd0;
  localparam logic [2:0] GRP_LD16  = 3'd1;
  localparam logic [2:0] GRP_LDIND = 3'd2;
  localparam logic [2:0] GRP_INC16 = 3'd3;
  localparam logic [2:0] GRP_INC8  = 3'd4;
  localparam logic [2:0] GRP_DEC8  = 3'd5;
  localparam logic [2:0] GRP_LD8   = 3'd6;
  localparam logic [2:0] GRP_ACC   = 3'd7;

  // Operand code that selects the byte at (HL).
  localparam logic [2:0] R_HL_IND = 3'd6;

  // Accumulator group operations.
  localparam logic [2:0] ACC_RLCA = 3'd0;
  localparam logic [2:0] ACC_RRCA = 3'd1;
  localparam logic [2:0] ACC_RLA  = 3'd2;
  localparam logic [2:0] ACC_DAA  = 3'd4;
  localparam logic [2:0] ACC_SCF  = 3'd6;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_WR2
  } state_t;

  // Operand code B,C,D,E,H,L,(HL),A to register file index.
  function automatic logic [2:0] r8_index(input logic [2:0] r);
    logic [2:0] idx;
    case (r)
      3'd0:    idx = 3'd2;
      3'd1:    idx = 3'd3;
      3'd2:    idx = 3'd4;
      3'd3:    idx = 3'd5;
      3'd4:    idx = 3'd6;
      3'd5:    idx = 3'd7;
      default: idx = IDX_A;
    endcase
    return idx;
  endfunction

endpackage

FILE: rtl/core/sm83_opcode_block0_execute_unit.sv
// SM83 execute unit for opcodes 0x00-0x3F, register file in flops, data memory in RAM.
// The byte at the selected pointer is read from the data RAM on input transfer; once the
// result register is free, the instruction executes and writes back. LD (a16),SP adds
// ST_WR2 for its second RAM write. A new instruction is taken only in ST_IDLE, after the
// last has committed. After reset the data RAM is cleared one byte a cycle, all 65536
// (2^MEM_ADDR_BITS) bytes, with no input taken; registers and SP reset to zero at once.
module sm83_opcode_block0_execute_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // opcode[5:0], imm_low[13:6], imm_high[21:14], zero fill above
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // cycles[4:0], length[6:5], branch_taken[7], branch_offset[15:8], acc_value[23:16],
  // flag_value[31:24], not_implemented[32], zero fill above
  output logic [39:0] m_tdata
);

  localparam int AW = sm83_pkg::MEM_ADDR_BITS;

  sm83_pkg::state_t state, state_next;

  logic [7:0]  rf [8];
  logic [7:0]  rf_next [8];
  logic [15:0] sp, sp_next;
  logic [5:0]  op;
  logic [7:0]  lo, hi;
  logic [AW-1:0] clr_cnt;
  logic [15:0] wr2_addr, wr2_addr_next;

  logic        in_xfer, exec_go;
  logic [15:0] bc, de, hl;
  logic [15:0] rd_addr16, ex_addr16;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_wdata, ram_rdata;

  // Execute results.
  logic          ex_we;
  logic [15:0]   ex_waddr;
  logic [7:0]    ex_wdata;
  logic          ex_second;
  logic [39:0]   ex_out;

  assign bc = {rf[2], rf[3]};
  assign de = {rf[4], rf[5]};
  assign hl = {rf[sm83_pkg::IDX_H], rf[sm83_pkg::IDX_L]};

  assign in_xfer = s_tvalid && s_tready;
  // The result register must be free before an instruction commits.
  assign exec_go = (state == sm83_pkg::ST_EXEC) && (!m_tvalid || m_tready);

  // Indirect loads through BC or DE use that pair; every other read goes through HL.
  always_comb begin
    if (s_tdata[2:0] == sm83_pkg::GRP_LDIND && s_tdata[5:4] == 2'd0) begin
      rd_addr16 = bc;
    end else if (s_tdata[2:0] == sm83_pkg::GRP_LDIND && s_tdata[5:4] == 2'd1) begin
      rd_addr16 = de;
    end else begin
      rd_addr16 = hl;
    end
    if (op[2:0] == sm83_pkg::GRP_LDIND && op[5:4] == 2'd0) begin
      ex_addr16 = bc;
    end else if (op[2:0] == sm83_pkg::GRP_LDIND && op[5:4] == 2'd1) begin
      ex_addr16 = de;
    end else begin
      ex_addr16 = hl;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sm83_pkg::ST_CLEAR: begin
        if (clr_cnt == {AW{1'b1}}) state_next = sm83_pkg::ST_IDLE;
      end
      sm83_pkg::ST_IDLE: begin
        if (in_xfer) state_next = sm83_pkg::ST_EXEC;
      end
      sm83_pkg::ST_EXEC: begin
        if (exec_go) state_next = ex_second ? sm83_pkg::ST_WR2 : sm83_pkg::ST_IDLE;
      end
      sm83_pkg::ST_WR2: begin
        state_next = sm83_pkg::ST_IDLE;
      end
      default: state_next = sm83_pkg::ST_IDLE;
    endcase
  end

  // Control outputs and RAM port.
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = clr_cnt;
    ram_wdata = 8'h00;
    ram_raddr = rd_addr16[AW-1:0];
    unique case (state)
      sm83_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      sm83_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      sm83_pkg::ST_EXEC: begin
        // Keep re-reading the operand byte while the result register is full.
        ram_raddr = ex_addr16[AW-1:0];
        ram_we    = exec_go && ex_we;
        ram_waddr = ex_waddr[AW-1:0];
        ram_wdata = ex_wdata;
      end
      sm83_pkg::ST_WR2: begin
        ram_we    = 1'b1;
        ram_waddr = wr2_addr[AW-1:0];
        ram_wdata = sp[15:8];
      end
      default: ;
    endcase
  end

  // Instruction datapath.
  always_comb begin
    logic [2:0]  r, z, hi_i, ri;
    logic [1:0]  p;
    logic        q;
    logic [4:0]  cyc;
    logic [1:0]  len;
    logic        taken, ni, cond;
    logic [7:0]  off, a, f, v, d;
    logic [15:0] w, pv;
    logic [16:0] sum;
    logic [12:0] hsum;

    r = op[5:3]; z = op[2:0]; p = op[5:4]; q = op[3];
    hi_i = {p, 1'b0} + 3'd2;
    ri = sm83_pkg::r8_index(r);
    cyc = 5'd4; len = 2'd1; taken = 1'b0; ni = 1'b0; off = 8'h00;
    a = rf[sm83_pkg::IDX_A];
    f = rf[sm83_pkg::IDX_F];
    rf_next = rf;
    sp_next = sp;
    ex_we = 1'b0;
    ex_waddr = hl;
    ex_wdata = 8'h00;
    ex_second = 1'b0;
    wr2_addr_next = wr2_addr;
    cond = 1'b0;
    pv = (p == 2'd0) ? bc : (p == 2'd1) ? de : (p == 2'd2) ? hl : sp;
    v = (r == sm83_pkg::R_HL_IND) ? ram_rdata : rf[ri];
    w = 16'h0000; sum = 17'h0; hsum = 13'h0; d = 8'h00;

    case (z)
      sm83_pkg::GRP_MISC: begin
        if (op == sm83_pkg::OP_NOP) begin
          cyc = 5'd4;
        end else if (op == sm83_pkg::OP_LD_A16_SP) begin
          ex_we = 1'b1;
          ex_waddr = {hi, lo};
          ex_wdata = sp[7:0];
          ex_second = 1'b1;
          wr2_addr_next = {hi, lo} + 16'd1;
          cyc = 5'd20; len = 2'd3;
        end else if (op == sm83_pkg::OP_JR || op == sm83_pkg::OP_JR_Z ||
                     op == sm83_pkg::OP_JR_C) begin
          cond = (op == sm83_pkg::OP_JR) || (op == sm83_pkg::OP_JR_Z && f[sm83_pkg::FZ]) ||
                 (op == sm83_pkg::OP_JR_C && f[sm83_pkg::FC]);
          len = 2'd2;
          if (cond) begin
            cyc = 5'd12; taken = 1'b1; off = lo;
          end else begin
            cyc = 5'd8;
          end
        end else begin
          ni = 1'b1;
        end
      end
      sm83_pkg::GRP_LD16: begin
        if (!q) begin
          if (p == 2'd3) sp_next = {hi, lo};
          else begin
            rf_next[hi_i] = hi;
            rf_next[hi_i + 3'd1] = lo;
          end
          cyc = 5'd12; len = 2'd3;
        end else begin
          w = pv;
          sum = {1'b0, hl} + {1'b0, w};
          hsum = {1'b0, hl[11:0]} + {1'b0, w[11:0]};
          f[sm83_pkg::FC] = sum[16];
          f[sm83_pkg::FH] = hsum[12];
          f[sm83_pkg::FN] = 1'b0;
          rf_next[sm83_pkg::IDX_H] = sum[15:8];
          rf_next[sm83_pkg::IDX_L] = sum[7:0];
          cyc = 5'd8;
        end
      end
      sm83_pkg::GRP_LDIND: begin
        if (!q) begin
          ex_we = 1'b1;
          ex_waddr = ex_addr16;
          ex_wdata = a;
        end else begin
          a = ram_rdata;
        end
        if (p == 2'd2) w = ex_addr16 + 16'd1;
        else w = ex_addr16 - 16'd1;
        if (p[1]) begin
          rf_next[sm83_pkg::IDX_H] = w[15:8];
          rf_next[sm83_pkg::IDX_L] = w[7:0];
        end
        cyc = 5'd8;
      end
      sm83_pkg::GRP_INC16: begin
        w = q ? pv - 16'd1 : pv + 16'd1;
        if (p == 2'd3) sp_next = w;
        else begin
          rf_next[hi_i] = w[15:8];
          rf_next[hi_i + 3'd1] = w[7:0];
        end
        cyc = 5'd8;
      end
      sm83_pkg::GRP_INC8, sm83_pkg::GRP_DEC8: begin
        d = (z == sm83_pkg::GRP_INC8) ? v + 8'd1 : v - 8'd1;
        f[sm83_pkg::FZ] = (d == 8'h00);
        f[sm83_pkg::FN] = (z == sm83_pkg::GRP_DEC8);
        f[sm83_pkg::FH] = (z == sm83_pkg::GRP_INC8) ? (v[3:0] == 4'hF) : (v[3:0] == 4'h0);
        if (r == sm83_pkg::R_HL_IND) begin
          ex_we = 1'b1; ex_waddr = hl; ex_wdata = d; cyc = 5'd12;
        end else if (ri == sm83_pkg::IDX_A) begin
          a = d;
        end else begin
          rf_next[ri] = d;
        end
      end
      sm83_pkg::GRP_LD8: begin
        if (r == 3'd3 || r == 3'd5 || r == 3'd7) begin
          ni = 1'b1;
        end else begin
          if (r == sm83_pkg::R_HL_IND) begin
            ex_we = 1'b1; ex_waddr = hl; ex_wdata = lo; cyc = 5'd12;
          end else begin
            rf_next[ri] = lo; cyc = 5'd8;
          end
          len = 2'd2;
        end
      end
      default: begin
        case (r)
          sm83_pkg::ACC_RLCA: begin
            f = {3'b000, a[7], 4'h0};
            a = {a[6:0], a[7]};
          end
          sm83_pkg::ACC_RRCA: begin
            f = {3'b000, a[0], 4'h0};
            a = {a[0], a[7:1]};
          end
          sm83_pkg::ACC_RLA: begin
            d = {a[6:0], f[sm83_pkg::FC]};
            f = {3'b000, a[7], 4'h0};
            a = d;
          end
          sm83_pkg::ACC_DAA: begin
            d = a;
            if (!f[sm83_pkg::FN]) begin
              if (f[sm83_pkg::FC] || d > 8'h99) begin
                d = d + 8'h60;
                f[sm83_pkg::FC] = 1'b1;
              end
              if (f[sm83_pkg::FH] || d[3:0] > 4'h9) d = d + 8'h06;
            end else begin
              if (f[sm83_pkg::FC]) d = d - 8'h60;
              if (f[sm83_pkg::FH]) d = d - 8'h06;
            end
            a = d;
            f[sm83_pkg::FZ] = (d == 8'h00);
            f[sm83_pkg::FH] = 1'b0;
          end
          sm83_pkg::ACC_SCF: begin
            f[sm83_pkg::FN] = 1'b0;
            f[sm83_pkg::FH] = 1'b0;
            f[sm83_pkg::FC] = 1'b1;
          end
          default: ni = 1'b1;
        endcase
      end
    endcase

    rf_next[sm83_pkg::IDX_A] = a;
    rf_next[sm83_pkg::IDX_F] = f;
    ex_out = {7'd0, ni, f, a, off, taken, len, cyc};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= sm83_pkg::ST_CLEAR;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
      sp       <= 16'h0000;
      for (int i = 0; i < 8; i++) rf[i] <= 8'h00;
    end else begin
      state <= state_next;
      if (state == sm83_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      if (exec_go) begin
        m_tvalid <= 1'b1;
        rf       <= rf_next;
        sp       <= sp_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op <= s_tdata[5:0];
      lo <= s_tdata[13:6];
      hi <= s_tdata[21:14];
    end
    if (exec_go) begin
      m_tdata  <= ex_out;
      wr2_addr <= wr2_addr_next;
    end
  end

  sm83_ram #(
    .WIDTH(8),
    .DEPTH(sm83_pkg::MEM_DEPTH)
  ) u_mem (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Nothing is taken in while the data RAM is still being cleared.
  a_no_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == sm83_pkg::ST_CLEAR) |-> !s_tready)
    else $error("input taken during RAM clear");

  // The low nibble of F is never set.
  a_f_low: assert property (@(posedge clk) disable iff (rst)
    rf[sm83_pkg::IDX_F][3:0] == 4'h0)
    else $error("F low nibble set");

  // A jump that is not taken reports no displacement.
  a_off_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[7]) |-> (m_tdata[15:8] == 8'h00))
    else $error("offset without taken branch");

  // The second store of SP follows the first, one address up.
  a_wr2_addr: assert property (@(posedge clk) disable iff (rst)
    (state == sm83_pkg::ST_WR2) |-> (ram_waddr == $past(ram_waddr) + 1'b1))
    else $error("SP high byte address mismatch");

  // SP only changes when an instruction commits, as does the register file.
  a_rf_commit: assert property (@(posedge clk) disable iff (rst)
    !$past(exec_go) && $past(!rst) |-> $stable(sp))
    else $error("SP changed outside commit");

endmodule

FILE: rtl/core/sm83_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sm83_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
